// File: hdl/r16alu_pkg.sv
// Shared types and constants for the 16-bit ALU with flags.
// Holds the opcode codes, the item and result payload structs.
// No dependencies.
`timescale 1ns / 1ps

package r16alu_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int OP_WIDTH   = 6;

    localparam logic [OP_WIDTH-1:0] OP_NOP     = 6'd0;
    localparam logic [OP_WIDTH-1:0] OP_ADD     = 6'd1;
    localparam logic [OP_WIDTH-1:0] OP_ADDI    = 6'd2;
    localparam logic [OP_WIDTH-1:0] OP_AND     = 6'd3;
    localparam logic [OP_WIDTH-1:0] OP_ANDN    = 6'd4;
    localparam logic [OP_WIDTH-1:0] OP_ASL     = 6'd5;
    localparam logic [OP_WIDTH-1:0] OP_ASR     = 6'd6;
    localparam logic [OP_WIDTH-1:0] OP_DEC     = 6'd7;
    localparam logic [OP_WIDTH-1:0] OP_INC     = 6'd8;
    localparam logic [OP_WIDTH-1:0] OP_JMP_LO  = 6'd9;
    localparam logic [OP_WIDTH-1:0] OP_JMP_HI  = 6'd13;
    localparam logic [OP_WIDTH-1:0] OP_LCH     = 6'd14;
    localparam logic [OP_WIDTH-1:0] OP_LCL     = 6'd15;
    localparam logic [OP_WIDTH-1:0] OP_LOAD    = 6'd16;
    localparam logic [OP_WIDTH-1:0] OP_LOADLIT = 6'd17;
    localparam logic [OP_WIDTH-1:0] OP_LSL     = 6'd18;
    localparam logic [OP_WIDTH-1:0] OP_LSR     = 6'd19;
    localparam logic [OP_WIDTH-1:0] OP_NAND    = 6'd20;
    localparam logic [OP_WIDTH-1:0] OP_NOR     = 6'd21;
    localparam logic [OP_WIDTH-1:0] OP_ONES    = 6'd22;
    localparam logic [OP_WIDTH-1:0] OP_OR      = 6'd23;
    localparam logic [OP_WIDTH-1:0] OP_ORN     = 6'd24;
    localparam logic [OP_WIDTH-1:0] OP_PASS    = 6'd25;
    localparam logic [OP_WIDTH-1:0] OP_NOT     = 6'd26;
    localparam logic [OP_WIDTH-1:0] OP_STORE   = 6'd27;
    localparam logic [OP_WIDTH-1:0] OP_SUB     = 6'd28;
    localparam logic [OP_WIDTH-1:0] OP_SUBD    = 6'd29;
    localparam logic [OP_WIDTH-1:0] OP_XNOR    = 6'd30;
    localparam logic [OP_WIDTH-1:0] OP_XOR     = 6'd31;
    localparam logic [OP_WIDTH-1:0] OP_ZEROS   = 6'd32;

    localparam logic [DATA_WIDTH-1:0] LOW_BYTE_MASK  = 16'h00ff;
    localparam logic [DATA_WIDTH-1:0] HIGH_BYTE_MASK = 16'hff00;

    typedef struct packed {
        logic [OP_WIDTH-1:0]   op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
    } item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result;
        logic                  zero;
        logic                  neg;
        logic                  negzero;
        logic                  overflow;
        logic                  carry;
    } res_t;

endpackage

// File: hdl/r16alu_exec.sv
// Combinational execute logic of the ALU: one opcode applied to the operands
// and to the previous result and flags. Depends on r16alu_pkg.
`timescale 1ns / 1ps

module r16alu_exec (
    input  r16alu_pkg::item_t item,
    input  r16alu_pkg::res_t  prev,
    output r16alu_pkg::res_t  next
);
    import r16alu_pkg::*;

    logic [DATA_WIDTH-1:0] add_y;
    logic                  add_cin;
    logic [DATA_WIDTH:0]   add_sum;
    logic [DATA_WIDTH-1:0] add_r;
    logic                  add_v;
    logic [DATA_WIDTH-1:0] r;
    logic                  v;
    logic                  c;
    logic                  set_flags;
    logic                  set_result;

    // One shared adder serves every arithmetic opcode.
    always_comb
    begin
        add_y   = item.b;
        add_cin = 1'b0;
        case (item.op)
            OP_ADDI:
            begin
                add_cin = 1'b1;
            end
            OP_DEC:
            begin
                add_y = '1;
            end
            OP_INC:
            begin
                add_y = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
            end
            OP_SUB:
            begin
                add_y   = ~item.b;
                add_cin = 1'b1;
            end
            OP_SUBD:
            begin
                add_y = ~item.b;
            end
            default:
            begin
                add_y   = item.b;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, item.a} + {1'b0, add_y} + {{DATA_WIDTH{1'b0}}, add_cin};
    assign add_r   = add_sum[DATA_WIDTH-1:0];
    assign add_v   = ~(item.a[DATA_WIDTH-1] ^ add_y[DATA_WIDTH-1])
                     & (item.a[DATA_WIDTH-1] ^ add_r[DATA_WIDTH-1]);

    always_comb
    begin
        r          = prev.result;
        v          = 1'b0;
        c          = 1'b0;
        set_flags  = 1'b1;
        set_result = 1'b1;
        case (item.op) inside
            OP_ADD, OP_ADDI, OP_DEC, OP_INC, OP_SUB, OP_SUBD:
            begin
                r = add_r;
                v = add_v;
                c = add_sum[DATA_WIDTH];
            end
            OP_AND:  r = item.a & item.b;
            OP_ANDN: r = ~item.a & item.b;
            OP_ASL:
            begin
                r = {item.a[DATA_WIDTH-2:0], 1'b0};
                v = item.a[DATA_WIDTH-1] ^ item.a[DATA_WIDTH-2];
                c = item.a[DATA_WIDTH-1];
            end
            OP_ASR:  r = {item.a[DATA_WIDTH-1], item.a[DATA_WIDTH-1:1]};
            [OP_JMP_LO:OP_JMP_HI]:
            begin
                r         = item.b;
                set_flags = 1'b0;
            end
            OP_LCH:
            begin
                r         = {item.b[DATA_WIDTH-9:0], 8'h00} | (prev.result & LOW_BYTE_MASK);
                set_flags = 1'b0;
            end
            OP_LCL:
            begin
                r         = item.b | (prev.result & HIGH_BYTE_MASK);
                set_flags = 1'b0;
            end
            OP_LSL:
            begin
                r = {item.a[DATA_WIDTH-2:0], 1'b0};
                c = item.a[DATA_WIDTH-1];
            end
            OP_LSR:  r = {1'b0, item.a[DATA_WIDTH-1:1]};
            OP_NAND: r = ~(item.a & item.b);
            OP_NOR:  r = ~(item.a | item.b);
            OP_ONES: r = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
            OP_OR:   r = item.a | item.b;
            OP_ORN:  r = item.a | ~item.b;
            OP_PASS: r = item.a;
            OP_NOT:  r = ~item.a;
            OP_XNOR: r = ~(item.a ^ item.b);
            OP_XOR:  r = item.a ^ item.b;
            OP_ZEROS: r = '0;
            default:
            begin
                // No operation, load, store and unassigned codes hold state.
                set_flags  = 1'b0;
                set_result = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        next        = prev;
        if (set_result)
        begin
            next.result = r;
        end
        if (set_flags)
        begin
            next.zero     = (r == '0);
            next.neg      = r[DATA_WIDTH-1];
            next.negzero  = (r == '0) | r[DATA_WIDTH-1];
            next.overflow = v;
            next.carry    = c;
        end
    end

endmodule

// File: hdl/risc16_alu_with_flags_core.sv
// Top level of the 16-bit ALU with zero, negative, overflow and carry flags.
// Depends on r16alu_pkg and r16alu_exec.
`timescale 1ns / 1ps

// Use of the block
// ----------------
// Items (opcode, operand a, operand b) arrive on the item channel and results
// (result word and five flags) leave on the res channel. Both channels use a
// valid/stall handshake: a transfer takes place at a rising edge where valid
// is high and stall is low.
// An accepted item is first captured in an input register. While it is held
// there the execute logic works out the new result and flags, which are
// written into the result register; that register is also the architectural
// state (previous result and flags) seen by the next item. The result is
// valid once the item has passed the input and result registers, and one
// item per cycle is sustained while the receiver does not stall; the rate is
// set by the single pass through the adder and the opcode selection.
// When the receiver stalls, the result register holds and the input register
// keeps one more item, so the item channel stalls only when both are full.
// Every item yields exactly one result, including no-operation codes, which
// simply repeat the current state.
// Reset clears both valid flags, the stored result and all flags.

module risc16_alu_with_flags_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  r16alu_pkg::item_t  item,
    output logic               res_valid,
    input  logic               res_stall,
    output r16alu_pkg::res_t   res
);
    import r16alu_pkg::*;

    item_t item_reg;
    logic  item_valid_reg;
    logic  item_valid_next;
    res_t  state_reg;
    res_t  state_next;
    logic  res_valid_reg;
    logic  res_valid_next;
    logic  advance;

    // The input register may move on whenever the result register is empty or
    // its contents are being transferred in this cycle.
    assign advance    = ~res_valid_reg | ~res_stall;
    assign item_stall = item_valid_reg & ~advance;

    r16alu_exec u_exec (
        .item (item_reg),
        .prev (state_reg),
        .next (state_next)
    );

    // The input register takes a new item whenever it is not held back, which
    // includes the case of an empty input register behind a stalled result.
    always_comb
    begin
        item_valid_next = item_valid_reg;
        res_valid_next  = res_valid_reg;
        if (advance)
        begin
            res_valid_next = item_valid_reg;
        end
        if (!item_stall)
        begin
            item_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
            if (advance && item_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload register: needs no reset, it is only read while marked valid.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = state_reg;

    // The negative-or-zero flag always agrees with the two flags it combines.
    a_negzero_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.negzero == (state_reg.zero | state_reg.neg))
        else $error("negzero flag out of step with zero and neg");

    // An item held back by a stalled output stays in the input register.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> item_valid_reg)
        else $error("held item lost from input register");

    // A no-operation item leaves result and flags untouched.
    a_nop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_valid_reg && item_reg.op == OP_NOP) |=> $stable(state_reg))
        else $error("no-operation item changed the state");

    // A result is pending after every item that leaves the input register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_valid_reg) |=> res_valid_reg)
        else $error("executed item produced no result");

endmodule
